// ===== hw/rtl/tdr_pkg.sv =====
// shared types, constants and helpers for the tile dirty rectangle detector
package tdr_pkg;

  localparam int DIM_W     = 15;     // width of dimensions and box edges
  localparam int CNT_W     = 14;     // width of pixel column and row counters
  localparam int DIM_LIMIT = 16384;  // largest frame width or height
  localparam int RES_W     = 17;     // headroom for tile edge products

  localparam int PIX_W = 32;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // one result item
  typedef struct packed {
    logic             changed;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
  } result_t;

  // status from the tracker to the top level
  typedef struct packed {
    logic    last;
    result_t result;
  } trk_status_t;

  // largest frame height the tile row range can hold
  function automatic int row_limit(input int tile_size, input int max_tile_rows);
    int lim;
    lim = tile_size * max_tile_rows;
    if (lim > DIM_LIMIT) lim = DIM_LIMIT;
    return lim;
  endfunction

endpackage

// ===== hw/rtl/tdr_track.sv =====
// position counters, tile bounds record and result forming for one frame
module tdr_track import tdr_pkg::*; #(
  parameter int TILE_SIZE     = 16,
  parameter int MAX_TILE_ROWS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             step,
  input  logic             differ,
  input  logic [DIM_W-1:0] w_eff,
  input  logic [DIM_W-1:0] h_eff,
  output trk_status_t      status
);

  localparam int COL_TILES = (DIM_LIMIT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int ROW_LIM   = row_limit(TILE_SIZE, MAX_TILE_ROWS);
  localparam int ROW_TILES = (ROW_LIM + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TC_W      = $clog2(COL_TILES);
  localparam int TR_W      = $clog2(ROW_TILES);
  localparam int OFF_W     = $clog2(TILE_SIZE);

  logic [CNT_W-1:0] col, col_next;
  logic [CNT_W-1:0] row, row_next;
  logic [OFF_W-1:0] col_off, col_off_next;
  logic [OFF_W-1:0] row_off, row_off_next;
  logic [TC_W-1:0]  tile_col, tile_col_next;
  logic [TR_W-1:0]  tile_row, tile_row_next;
  logic             any_diff, any_diff_next;
  logic [TC_W-1:0]  min_tc, min_tc_next, max_tc, max_tc_next;
  logic [TR_W-1:0]  min_tr, min_tr_next, max_tr, max_tr_next;

  logic [CNT_W-1:0] w_last, h_last;
  logic             col_last, row_last, frame_last;
  logic [RES_W-1:0] left_raw, top_raw, right_raw, bottom_raw;
  result_t          res;

  assign w_last     = CNT_W'(w_eff - DIM_W'(1));
  assign h_last     = CNT_W'(h_eff - DIM_W'(1));
  assign col_last   = (col == w_last);
  assign row_last   = (row == h_last);
  assign frame_last = col_last && row_last;

  // bounds including the current pixel
  always_comb begin
    any_diff_next = any_diff;
    min_tc_next   = min_tc;
    max_tc_next   = max_tc;
    min_tr_next   = min_tr;
    max_tr_next   = max_tr;
    if (differ) begin
      any_diff_next = 1'b1;
      if (!any_diff) begin
        min_tc_next = tile_col;
        max_tc_next = tile_col;
        min_tr_next = tile_row;
        max_tr_next = tile_row;
      end else begin
        if (tile_col < min_tc) min_tc_next = tile_col;
        if (tile_col > max_tc) max_tc_next = tile_col;
        if (tile_row < min_tr) min_tr_next = tile_row;
        if (tile_row > max_tr) max_tr_next = tile_row;
      end
    end
  end

  // raster position advance
  always_comb begin
    col_next      = col + CNT_W'(1);
    col_off_next  = col_off + OFF_W'(1);
    tile_col_next = tile_col;
    row_next      = row;
    row_off_next  = row_off;
    tile_row_next = tile_row;
    if (col_off == OFF_W'(TILE_SIZE - 1)) begin
      col_off_next  = '0;
      tile_col_next = tile_col + TC_W'(1);
    end
    if (col_last) begin
      col_next      = '0;
      col_off_next  = '0;
      tile_col_next = '0;
      row_next      = row + CNT_W'(1);
      row_off_next  = row_off + OFF_W'(1);
      if (row_off == OFF_W'(TILE_SIZE - 1)) begin
        row_off_next  = '0;
        tile_row_next = tile_row + TR_W'(1);
      end
      if (row_last) begin
        row_next      = '0;
        row_off_next  = '0;
        tile_row_next = '0;
      end
    end
  end

  // box from the bounds as they stand after this pixel
  always_comb begin
    left_raw   = RES_W'(min_tc_next) * RES_W'(TILE_SIZE);
    top_raw    = RES_W'(min_tr_next) * RES_W'(TILE_SIZE);
    right_raw  = (RES_W'(max_tc_next) + RES_W'(1)) * RES_W'(TILE_SIZE);
    bottom_raw = (RES_W'(max_tr_next) + RES_W'(1)) * RES_W'(TILE_SIZE);
    if (right_raw > RES_W'(w_eff))  right_raw  = RES_W'(w_eff);
    if (bottom_raw > RES_W'(h_eff)) bottom_raw = RES_W'(h_eff);
    res = '0;
    if (any_diff_next) begin
      res.changed = 1'b1;
      res.left    = left_raw[DIM_W-1:0];
      res.top     = top_raw[DIM_W-1:0];
      res.right   = right_raw[DIM_W-1:0];
      res.bottom  = bottom_raw[DIM_W-1:0];
    end
  end

  assign status.last   = frame_last;
  assign status.result = res;

  always_ff @(posedge clk) begin
    if (rst || clear || (step && frame_last)) begin
      col      <= '0;
      row      <= '0;
      col_off  <= '0;
      row_off  <= '0;
      tile_col <= '0;
      tile_row <= '0;
      any_diff <= 1'b0;
      min_tc   <= '0;
      max_tc   <= '0;
      min_tr   <= '0;
      max_tr   <= '0;
    end else if (step) begin
      col      <= col_next;
      row      <= row_next;
      col_off  <= col_off_next;
      row_off  <= row_off_next;
      tile_col <= tile_col_next;
      tile_row <= tile_row_next;
      any_diff <= any_diff_next;
      min_tc   <= min_tc_next;
      max_tc   <= max_tc_next;
      min_tr   <= min_tr_next;
      max_tr   <= max_tr_next;
    end
  end

endmodule

// ===== hw/rtl/tile_dirty_rectangle_32bpp.sv =====
// top level of the tile dirty rectangle detector for 32-bit pixel pairs
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_ready    pixel_first, pixel_second
//  out      out_valid / out_ready  changed, box_left, box_top, box_right,
//                                  box_bottom
//  cfg      cfg_we                 cfg_index, cfg_data (no wait, no read-back)
//
// one pixel pair a cycle unless the input stalls as below: an item is held in
// the input register, where the compare and the bounds update run, then moves
// into the tracker state; the last pixel of a frame also loads the result register.
// out_valid rises as the last pixel of a frame leaves the input register.
// synchronous reset sets width 1920, height 1080 and clears the frame.
// the input stalls only when the last pixel of a frame waits on a full
// result register that is not being taken; other pixels flow regardless.
// a write to either register restarts the frame and drops any partial box.
module tile_dirty_rectangle_32bpp import tdr_pkg::*; #(
  parameter int TILE_SIZE     = 16,
  parameter int MAX_TILE_ROWS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel_first,
  input  logic [PIX_W-1:0] pixel_second,
  // output channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             changed,
  output logic [DIM_W-1:0] box_left,
  output logic [DIM_W-1:0] box_top,
  output logic [DIM_W-1:0] box_right,
  output logic [DIM_W-1:0] box_bottom
);

  localparam int ROW_LIM = row_limit(TILE_SIZE, MAX_TILE_ROWS);

  // configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             frame_clear;

  // effective dimensions after range folding
  logic [DIM_W-1:0] w_eff, h_eff;

  // input register
  logic             s1_valid;
  logic [PIX_W-1:0] s1_first, s1_second;
  logic             in_accept;
  logic             step;

  // result register
  result_t          out_res;

  trk_status_t      trk_status;

  // register writes, any known index restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1920);
      frame_height <= DIM_W'(1080);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign frame_clear = cfg_we &&
                       ((reg_index_t'(cfg_index) == REG_FRAME_WIDTH) ||
                        (reg_index_t'(cfg_index) == REG_FRAME_HEIGHT));

  // zero counts as one, big values saturate
  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) w_eff = DIM_W'(1);
    else if (frame_width > DIM_W'(DIM_LIMIT)) w_eff = DIM_W'(DIM_LIMIT);
    h_eff = frame_height;
    if (frame_height == '0) h_eff = DIM_W'(1);
    else if (frame_height > DIM_W'(ROW_LIM)) h_eff = DIM_W'(ROW_LIM);
  end

  // the held item moves on unless it closes a frame and the result slot is busy
  assign step      = s1_valid && (!trk_status.last || !out_valid || out_ready);
  assign in_ready  = !s1_valid || step;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  // pixel payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_first  <= pixel_first;
      s1_second <= pixel_second;
    end
  end

  tdr_track #(
    .TILE_SIZE     (TILE_SIZE),
    .MAX_TILE_ROWS (MAX_TILE_ROWS)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .clear  (frame_clear),
    .step   (step),
    .differ (s1_first != s1_second),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .status (trk_status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && trk_status.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && trk_status.last) begin
      out_res <= trk_status.result;
    end
  end

  assign changed    = out_res.changed;
  assign box_left   = out_res.left;
  assign box_top    = out_res.top;
  assign box_right  = out_res.right;
  assign box_bottom = out_res.bottom;

  // an unchanged frame reports an empty box
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !changed) |->
      (box_left == '0 && box_top == '0 && box_right == '0 && box_bottom == '0))
    else $error("unchanged frame with nonzero box");

  // a changed box always has positive extent
  a_box_extent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && changed) |-> (box_right > box_left && box_bottom > box_top))
    else $error("changed box without extent");

  // a frame end blocked by a waiting result holds the input
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && trk_status.last && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while frame end is blocked");

  // a new result only comes from a frame end that moved on
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && trk_status.last))
    else $error("result appeared without a frame end");

endmodule
